FILE: hdl/quadratic_root_solver_assert.svh
// Assertion macros shared by the quadratic root solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/qrs_pkg.sv
// Package: widths, result kinds and pipeline sideband types of the root solver.
package qrs_pkg;

    // Coefficient and result format
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;

    // Discriminant magnitude below 2^65, its floor root below 2^33
    localparam int DMAG_W    = 65;
    localparam int SQ_W      = DMAG_W + 1;
    localparam int ROOT_W    = 33;
    localparam int SQ_STEPS  = 33;

    // Negated b, numerator magnitude, divisor 2|a| and divider remainder
    localparam int NB_W      = VAL_W + 1;
    localparam int NMAG_W    = 34;
    localparam int NUM_W     = NMAG_W + FRAC_BITS;
    localparam int DEN_W     = VAL_W + 1;
    localparam int REM_W     = DEN_W + 1;

    typedef enum logic [1:0] {
        KIND_REAL    = 2'd0,
        KIND_DOUBLE  = 2'd1,
        KIND_COMPLEX = 2'd2,
        KIND_DEGEN   = 2'd3
    } root_kind_t;

    // Per-item data that rides along the whole pipeline
    typedef struct packed {
        root_kind_t              kind;
        logic                    a_neg;
        logic                    opp_sign;
        logic [DEN_W-1:0]        den;
        logic signed [NB_W-1:0]  nb;
    } side_t;

    // One divider lane
    typedef struct packed {
        logic                    neg;
        logic [REM_W-1:0]        rem;
        logic [NUM_W-1:0]        num;
        logic [NUM_W-1:0]        quo;
    } lane_t;

endpackage

FILE: hdl/quadratic_root_solver.sv
// Pipelined quadratic root solver: discriminant, square root, two dividers, saturation.
//
// Takes one coefficient set (a, b, c in signed Q16.16) every clock cycle while the
// output side does not stall, and returns one result item per input, in order. The depth
// is set by the 33-step bit-serial square root and the 50-step restoring dividers, each
// step a register stage; the whole pipeline holds while a result waits at the output.
// root_kind in tuser tells real distinct, double, complex pair or a == 0; square roots
// floor, divisions truncate toward zero, and values clamp to the 32-bit range with the
// saturated flag set.

`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // first_value [31:0], second_value [63:32]
    output logic [2:0]  m_axis_tuser    // root_kind [1:0], saturated [2]
);
    import qrs_pkg::*;

    // Stage numbers
    localparam int SQ0  = 3;
    localparam int NUMS = SQ0 + SQ_STEPS;
    localparam int DV0  = NUMS + 1;
    localparam int OUTS = DV0 + NUM_W;

    logic [OUTS:0] vld_reg;
    logic          pipe_en;

    // Stage 0: input register
    logic signed [VAL_W-1:0] a0_reg, b0_reg, c0_reg;
    // Stage 1: products
    logic [2*VAL_W-1:0]      bb_reg, ac_reg;
    logic [2*VAL_W-1:0]      bb_next, ac_next;
    // Stage 2: discriminant magnitude
    logic [DMAG_W-1:0]       dmag_reg, dmag_next;
    // Sideband for stages 1 .. OUTS-1
    side_t                   side_reg [1:OUTS-1];
    side_t                   side1_next, side2_next;
    // Square root stages
    logic [SQ_W-1:0]         sq_rem_reg  [SQ_STEPS];
    logic [SQ_W-1:0]         sq_root_reg [SQ_STEPS];
    logic [SQ_W-1:0]         sq_rem_next [SQ_STEPS];
    logic [SQ_W-1:0]         sq_root_next[SQ_STEPS];
    // Divider lanes, numerator stage onward
    lane_t                   lane_reg [NUMS:OUTS-1][2];
    lane_t                   lane_next[NUMS:OUTS-1][2];
    // Output register
    root_kind_t              kind_reg;
    logic [VAL_W-1:0]        first_reg, second_reg;
    logic                    sat_reg;
    logic [VAL_W-1:0]        first_next, second_next;
    logic                    sat_next;

    // Whole pipeline advances unless a result is held at the output
    assign pipe_en       = !vld_reg[OUTS] || m_axis_tready;
    assign s_axis_tready = pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[OUTS-1:0], s_axis_tvalid};
        end
    end

    // Stage 1 logic: magnitudes, products, sideband
    always_comb
    begin
        logic [VAL_W-1:0] a_mag, b_mag, c_mag;
        a_mag = a0_reg[VAL_W-1] ? VAL_W'(-a0_reg) : VAL_W'(a0_reg);
        b_mag = b0_reg[VAL_W-1] ? VAL_W'(-b0_reg) : VAL_W'(b0_reg);
        c_mag = c0_reg[VAL_W-1] ? VAL_W'(-c0_reg) : VAL_W'(c0_reg);
        bb_next = b_mag * b_mag;
        ac_next = a_mag * c_mag;
        side1_next.kind     = (a0_reg == '0) ? KIND_DEGEN : KIND_REAL;
        side1_next.a_neg    = a0_reg[VAL_W-1];
        side1_next.opp_sign = (a0_reg[VAL_W-1] != c0_reg[VAL_W-1]) && (c0_reg != '0);
        side1_next.den      = {a_mag, 1'b0};
        side1_next.nb       = -NB_W'(b0_reg);
    end

    // Stage 2 logic: sign and magnitude of b*b - 4ac
    always_comb
    begin
        logic [DMAG_W-1:0] p, q;
        p = DMAG_W'(bb_reg);
        q = DMAG_W'({ac_reg, 2'b00});
        side2_next = side_reg[1];
        if (side_reg[1].opp_sign)
        begin
            dmag_next = p + q;
            if (side_reg[1].kind != KIND_DEGEN) side2_next.kind = KIND_REAL;
        end
        else if (p > q)
        begin
            dmag_next = p - q;
            if (side_reg[1].kind != KIND_DEGEN) side2_next.kind = KIND_REAL;
        end
        else if (p < q)
        begin
            dmag_next = q - p;
            if (side_reg[1].kind != KIND_DEGEN) side2_next.kind = KIND_COMPLEX;
        end
        else
        begin
            dmag_next = '0;
            if (side_reg[1].kind != KIND_DEGEN) side2_next.kind = KIND_DOUBLE;
        end
    end

    // Square root: one result bit per stage, highest power of four first
    for (genvar j = 0; j < SQ_STEPS; j++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
        logic [SQ_W-1:0] rem_in, root_in, trial;
        if (j == 0)
        begin : g_first
            assign rem_in  = SQ_W'(dmag_reg);
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
        end
        assign trial = root_in + BIT;
        always_comb
        begin
            if (rem_in >= trial)
            begin
                sq_rem_next[j]  = rem_in - trial;
                sq_root_next[j] = (root_in >> 1) + BIT;
            end
            else
            begin
                sq_rem_next[j]  = rem_in;
                sq_root_next[j] = root_in >> 1;
            end
        end
    end

    // Numerator stage: pick numerators by kind, split sign and magnitude
    always_comb
    begin
        logic signed [NMAG_W:0] s_val, nb_val, n1, n2;
        logic [NMAG_W-1:0]      m1, m2;
        s_val  = (NMAG_W+1)'(sq_root_reg[SQ_STEPS-1][ROOT_W-1:0]);
        nb_val = (NMAG_W+1)'(side_reg[NUMS-1].nb);
        n1 = nb_val + s_val;
        n2 = nb_val - s_val;
        if (side_reg[NUMS-1].kind == KIND_COMPLEX)
        begin
            n1 = nb_val;
            n2 = s_val;
        end
        m1 = n1[NMAG_W] ? NMAG_W'(-n1) : NMAG_W'(n1);
        m2 = n2[NMAG_W] ? NMAG_W'(-n2) : NMAG_W'(n2);
        lane_next[NUMS][0].neg = n1[NMAG_W] != side_reg[NUMS-1].a_neg;
        lane_next[NUMS][0].rem = '0;
        lane_next[NUMS][0].num = {m1, {FRAC_BITS{1'b0}}};
        lane_next[NUMS][0].quo = '0;
        lane_next[NUMS][1].neg = n2[NMAG_W] != side_reg[NUMS-1].a_neg;
        lane_next[NUMS][1].rem = '0;
        lane_next[NUMS][1].num = {m2, {FRAC_BITS{1'b0}}};
        lane_next[NUMS][1].quo = '0;
    end

    // Restoring divide by 2|a|: one quotient bit per stage in each lane
    for (genvar j = 0; j < NUM_W; j++)
    begin : g_div
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            always_comb
            begin
                lane_t            cur;
                logic [REM_W-1:0] rsh, dext;
                cur  = lane_reg[DV0+j-1][l];
                dext = REM_W'(side_reg[DV0+j-1].den);
                rsh  = {cur.rem[REM_W-2:0], cur.num[NUM_W-1]};
                lane_next[DV0+j][l].neg = cur.neg;
                lane_next[DV0+j][l].num = {cur.num[NUM_W-2:0], 1'b0};
                if (rsh >= dext)
                begin
                    lane_next[DV0+j][l].rem = rsh - dext;
                    lane_next[DV0+j][l].quo = {cur.quo[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    lane_next[DV0+j][l].rem = rsh;
                    lane_next[DV0+j][l].quo = {cur.quo[NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    // Output stage: sign, clamp, degenerate override
    always_comb
    begin
        logic [NUM_W-1:0] q0, q1;
        logic             s0, s1;
        logic [VAL_W-1:0] v0, v1;
        q0 = lane_reg[OUTS-1][0].quo;
        q1 = lane_reg[OUTS-1][1].quo;
        s0 = 1'b0;
        s1 = 1'b0;
        if (lane_reg[OUTS-1][0].neg && q0 != '0)
        begin
            if (q0 > NUM_W'(33'h080000000))
            begin
                s0 = 1'b1;
                v0 = 32'h80000000;
            end
            else v0 = -q0[VAL_W-1:0];
        end
        else if (q0 > NUM_W'(32'h7FFFFFFF))
        begin
            s0 = 1'b1;
            v0 = 32'h7FFFFFFF;
        end
        else v0 = q0[VAL_W-1:0];
        if (lane_reg[OUTS-1][1].neg && q1 != '0)
        begin
            if (q1 > NUM_W'(33'h080000000))
            begin
                s1 = 1'b1;
                v1 = 32'h80000000;
            end
            else v1 = -q1[VAL_W-1:0];
        end
        else if (q1 > NUM_W'(32'h7FFFFFFF))
        begin
            s1 = 1'b1;
            v1 = 32'h7FFFFFFF;
        end
        else v1 = q1[VAL_W-1:0];
        case (side_reg[OUTS-1].kind)
            KIND_DEGEN:
            begin
                first_next  = '0;
                second_next = '0;
                sat_next    = 1'b0;
            end
            KIND_DOUBLE:
            begin
                first_next  = v0;
                second_next = v0;
                sat_next    = s0;
            end
            default:
            begin
                first_next  = v0;
                second_next = v1;
                sat_next    = s0 | s1;
            end
        endcase
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a0_reg      <= s_axis_tdata[31:0];
            b0_reg      <= s_axis_tdata[63:32];
            c0_reg      <= s_axis_tdata[95:64];
            bb_reg      <= bb_next;
            ac_reg      <= ac_next;
            side_reg[1] <= side1_next;
            side_reg[2] <= side2_next;
            dmag_reg    <= dmag_next;
            for (int i = 3; i < OUTS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int j = 0; j < SQ_STEPS; j++)
            begin
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
            end
            for (int i = NUMS; i < OUTS; i++)
            begin
                lane_reg[i][0] <= lane_next[i][0];
                lane_reg[i][1] <= lane_next[i][1];
            end
            kind_reg   <= side_reg[OUTS-1].kind;
            first_reg  <= first_next;
            second_reg <= second_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_axis_tvalid = vld_reg[OUTS];
    assign m_axis_tdata  = {second_reg, first_reg};
    assign m_axis_tuser  = {sat_reg, kind_reg};

    // Checks
    `QRS_ASSERT_NOW(a_degen_zero,
        m_axis_tvalid && kind_reg == KIND_DEGEN,
        first_reg == '0 && second_reg == '0 && !sat_reg,
        "degenerate item with nonzero values")
    `QRS_ASSERT_NOW(a_double_same,
        m_axis_tvalid && kind_reg == KIND_DOUBLE,
        first_reg == second_reg,
        "double root with differing values")
    `QRS_ASSERT_NOW(a_sat_at_limit,
        m_axis_tvalid && sat_reg,
        first_reg == 32'h7FFFFFFF || first_reg == 32'h80000000 ||
        second_reg == 32'h7FFFFFFF || second_reg == 32'h80000000,
        "saturated flag without a clamped value")
    `QRS_ASSERT_NEXT(a_stall_holds,
        !pipe_en,
        $stable(vld_reg),
        "pipeline moved during stall")

endmodule

FILE: tb/sv/testbench.sv
// Testbench for the quadratic root solver: random and directed coefficient sets, in-order check.
`timescale 1ns / 100ps

module testbench;

    import qrs_pkg::*;

    typedef struct {
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } coef_t;

    typedef struct {
        root_kind_t         kind;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic               sat;
    } roots_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // coef_a [31:0], coef_b [63:32], coef_c [95:64]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // first_value [31:0], second_value [63:32]
    logic [2:0]  m_axis_tuser;   // root_kind [1:0], saturated [2]

    coef_t  pending_coefs[$];
    roots_t expected_roots[$];
    int     fail_count;
    int     roots_seen;
    int     kind_seen[4];
    int     sat_seen;
    int     sent_count;
    int     cycle_count;
    bit     stim_done;
    bit     steady_send;
    bit     steady_recv;
    int     hold_off;

    quadratic_root_solver i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // (n << FRAC_BITS) / (2a), truncated toward zero, clamped to 32 bits
    function automatic logic [31:0] divide_root(input logic signed [127:0] n,
                                                input logic signed [127:0] a,
                                                inout logic sat);
        logic [127:0] nm;
        logic [127:0] am;
        logic [127:0] q;
        logic         neg;
        nm  = (n < 0) ? -n : n;
        am  = (a < 0) ? -a : a;
        q   = (nm << FRAC_BITS) / (am * 2);
        neg = ((n < 0) != (a < 0)) && (q != 0);
        if (neg)
        begin
            if (q > 128'h8000_0000)
            begin
                sat = 1'b1;
                q   = 128'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 128'h7FFF_FFFF)
        begin
            sat = 1'b1;
            q   = 128'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    // Floored square root of a value below 2^70
    function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  cand;
        r = 0;
        for (int bit_i = 34; bit_i >= 0; bit_i--)
        begin
            cand = r | (64'd1 << bit_i);
            if (128'(cand) * 128'(cand) <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic roots_t solve_roots(input coef_t k);
        roots_t             r;
        logic signed [127:0] a;
        logic signed [127:0] b;
        logic signed [127:0] c;
        logic signed [127:0] disc;
        logic signed [127:0] s;
        logic               sat;
        a   = k.a;
        b   = k.b;
        c   = k.c;
        sat = 1'b0;
        if (a == 0)
        begin
            r.kind   = KIND_DEGEN;
            r.first  = '0;
            r.second = '0;
            r.sat    = 1'b0;
            return r;
        end
        disc = b * b - 4 * a * c;
        s    = floor_sqrt(disc < 0 ? -disc : disc);
        if (disc > 0)
        begin
            r.kind   = KIND_REAL;
            r.first  = divide_root(-b + s, a, sat);
            r.second = divide_root(-b - s, a, sat);
        end
        else if (disc == 0)
        begin
            r.kind   = KIND_DOUBLE;
            r.first  = divide_root(-b, a, sat);
            r.second = r.first;
        end
        else
        begin
            r.kind   = KIND_COMPLEX;
            r.first  = divide_root(-b, a, sat);
            r.second = divide_root(s, a, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    function automatic logic [31:0] pick_value(input int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            2: return 32'($signed($urandom_range(0, 2048)) - 1024) <<< 16;
            3: return 32'($signed($urandom_range(0, 200)) - 100);
            default: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic add_coefs(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
        coef_t k;
        k.a = a;
        k.b = b;
        k.c = c;
        pending_coefs.push_back(k);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset, then fill the stimulus queue
    initial
    begin
        logic signed [31:0] r1;
        logic signed [31:0] r2;
        logic signed [31:0] a;
        rst_n         = 1'b0;
        stim_done     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: degenerate, each kind, extremes, sign of a
        add_coefs(32'd0, 32'h0001_0000, 32'h0005_0000);
        add_coefs(32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        add_coefs(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);   // x^2-3x+2
        add_coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);   // double root 1
        add_coefs(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);   // complex +-i
        add_coefs(32'hFFFF_0000, 32'h0000_0000, 32'hFFFF_0000);   // imaginary sign from a
        add_coefs(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000);
        add_coefs(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);   // saturation
        add_coefs(32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
        add_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_coefs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        add_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_coefs(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);   // double root zero
        add_coefs(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        add_coefs(32'h8000_0000, 32'h0000_0000, 32'h0000_0000);
        add_coefs(32'h0002_0000, 32'h0000_0000, 32'hFFF8_0000);

        // Random: two fifths built from chosen roots for double and distinct cases
        for (int i = 0; i < 1850; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // a(x-r)^2: b = -2ar, c = a r^2, small integers
                    a  = 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
                    r1 = $signed($urandom_range(0, 60)) - 30;
                    add_coefs(a, 32'(-2 * a * r1), 32'(a * r1 * r1));
                end
                2, 3:
                begin
                    a  = 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
                    r1 = $signed($urandom_range(0, 60)) - 30;
                    r2 = $signed($urandom_range(0, 60)) - 30;
                    add_coefs(a, 32'(-a * (r1 + r2)), 32'(a * r1 * r2));
                end
                4:
                    add_coefs(32'd0, $urandom, $urandom);
                default:
                    add_coefs(pick_value($urandom_range(0, 4)),
                              pick_value($urandom_range(0, 4)),
                              pick_value($urandom_range(0, 4)));
            endcase
        end
        stim_done = 1'b1;
    end

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        coef_t k;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            cycle_count   <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (s_axis_tvalid && s_axis_tready)
            begin
                k.a = s_axis_tdata[31:0];
                k.b = s_axis_tdata[63:32];
                k.c = s_axis_tdata[95:64];
                expected_roots.push_back(solve_roots(k));
                sent_count <= sent_count + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_coefs.size() > 0 &&
                    (steady_send || $urandom_range(0, 99) >= 23))
                begin
                    k = pending_coefs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {k.c, k.b, k.a};
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // No idling at all for a stretch in the middle of the run
    always @(posedge clk)
    begin
        steady_send <= (cycle_count > 800 && cycle_count < 1200);
        steady_recv <= (cycle_count > 800 && cycle_count < 1200);
    end

    // Receiver ready, with one long hold-off while the sender keeps going
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_off      <= 0;
        end
        else
        begin
            if (cycle_count == 300)
                hold_off <= 400;
            else if (hold_off > 0)
                hold_off <= hold_off - 1;
            if (cycle_count == 300 || hold_off > 1)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= steady_recv || ($urandom_range(0, 99) >= 23);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_roots.size() == 0)
            begin
                $error("result with no input waiting: tdata %h tuser %h",
                       m_axis_tdata, m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_roots.pop_front();
                roots_seen++;
                kind_seen[want.kind]++;
                if (want.sat)
                    sat_seen++;
                if (m_axis_tuser[1:0] !== want.kind)
                begin
                    $error("root_kind: expected %0d, got %0d", want.kind, m_axis_tuser[1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[31:0] !== want.first)
                begin
                    $error("first_value: expected %h, got %h", want.first, m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (m_axis_tdata[63:32] !== want.second)
                begin
                    $error("second_value: expected %h, got %h",
                           want.second, m_axis_tdata[63:32]);
                    fail_count++;
                end
                if (m_axis_tuser[2] !== want.sat)
                begin
                    $error("saturated: expected %0d, got %0d", want.sat, m_axis_tuser[2]);
                    fail_count++;
                end
            end
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        while (pending_coefs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_roots.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Sent %0d coefficient sets, checked %0d: %0d distinct, %0d double,",
                 sent_count, roots_seen, kind_seen[0], kind_seen[1]);
        $display("%0d complex, %0d with a zero, %0d saturated.",
                 kind_seen[2], kind_seen[3], sat_seen);
        if (fail_count == 0 && expected_roots.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

FILE: quadratic_root_solver.f
+incdir+hdl
hdl/qrs_pkg.sv
hdl/quadratic_root_solver.sv
tb/sv/testbench.sv
